>>> design/pscm_pkg.sv
// ----------------------------------------------------------------------------
// pscm_pkg - shared types and constants for the per-slot counter merge table
// Sizes, stream field positions, command codes and the search token.
// ----------------------------------------------------------------------------
package pscm_pkg;

    // Table size and key width
    localparam int SLOTS     = 128;
    localparam int KEY_WIDTH = 64;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Stream field widths
    localparam int CMD_W  = 2;
    localparam int KEY_W  = 64;
    localparam int SLOT_W = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 1;

    // Slave tdata: thread_key, slot, amount (lowest first), padded to bytes
    localparam int S_KEY_LSB  = 0;
    localparam int S_SLOT_LSB = S_KEY_LSB + KEY_W;
    localparam int S_AMT_LSB  = S_SLOT_LSB + SLOT_W;
    localparam int S_USED_W   = S_AMT_LSB + VAL_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = CMD_W;

    // Master tdata: slot_out, weak_value, global_total, padded to bytes
    localparam int M_SLOT_LSB = 0;
    localparam int M_WEAK_LSB = M_SLOT_LSB + SLOT_W;
    localparam int M_GLOB_LSB = M_WEAK_LSB + VAL_W;
    localparam int M_USED_W   = M_GLOB_LSB + VAL_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = STAT_W;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_MERGE  = 2'd2,
        CMD_READ   = 2'd3
    } pscm_cmd_t;

    // Search token walking the row of key cells
    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic [IDX_W-1:0]     idx;
        logic [KEY_WIDTH-1:0] key;
    } pscm_tok_t;

endpackage

>>> design/pscm_cell.sv
// ----------------------------------------------------------------------------
// pscm_cell - one key cell of the slot table
// Holds one key and its in-use flag; matches or claims a passing token.
// ----------------------------------------------------------------------------
module pscm_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [pscm_pkg::IDX_W-1:0] my_idx,
    input  pscm_pkg::pscm_tok_t        tok_in,
    output pscm_pkg::pscm_tok_t        tok_out
);
    import pscm_pkg::*;

    logic                 used_reg;
    logic                 used_next;
    logic [KEY_WIDTH-1:0] key_reg;
    logic                 tok_valid_reg;
    logic                 tok_hit_reg;
    logic [IDX_W-1:0]     tok_idx_reg;
    logic [KEY_WIDTH-1:0] tok_key_reg;
    pscm_tok_t            tok_next;
    logic                 live;
    logic                 claim;
    logic                 match;

    // Used cells form a prefix, so the first free cell a missed token meets
    // is the next slot to give out
    assign live  = tok_in.valid && !tok_in.hit;
    assign claim = live && !used_reg;
    assign match = live && used_reg && (key_reg == tok_in.key);

    always_comb begin
        tok_next  = tok_in;
        used_next = used_reg | claim;
        if (claim || match) begin
            tok_next.hit = 1'b1;
            tok_next.idx = my_idx;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end else begin
            used_reg      <= used_next;
            tok_valid_reg <= tok_next.valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (claim) begin
            key_reg <= tok_in.key;
        end
        tok_hit_reg <= tok_next.hit;
        tok_idx_reg <= tok_next.idx;
        tok_key_reg <= tok_next.key;
    end

    always_comb begin
        tok_out.valid = tok_valid_reg;
        tok_out.hit   = tok_hit_reg;
        tok_out.idx   = tok_idx_reg;
        tok_out.key   = tok_key_reg;
    end

endmodule

>>> design/pscm_chain.sv
// ----------------------------------------------------------------------------
// pscm_chain - row of key cells
// A lookup token enters cell 0 and moves one cell per clock to the end.
// ----------------------------------------------------------------------------
module pscm_chain (
    input  logic                aclk,
    input  logic                aresetn,
    input  pscm_pkg::pscm_tok_t tok_in,
    output pscm_pkg::pscm_tok_t tok_out
);
    import pscm_pkg::*;

    pscm_tok_t link [SLOTS+1];

    assign link[0] = tok_in;

    // One cell per slot, each knowing its own slot number
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        pscm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .my_idx  (IDX_W'(i)),
            .tok_in  (link[i]),
            .tok_out (link[i+1])
        );
    end

    assign tok_out = link[SLOTS];

endmodule

>>> design/per_slot_counter_merge_table_top.sv
// ----------------------------------------------------------------------------
// per_slot_counter_merge_table_top - per-slot counters with a merged total
//
//  channel | dir | transaction
//  --------+-----+------------------------------------------------------------
//  s_      | in  | command in tuser; key, slot, amount in tdata
//  m_      | out | slot_out, weak_value, global_total in tdata; status in tuser
//
// Add, merge and plain read accept with the count memory read, then update and
// result. A lookup's key first walks the row of key cells one cell per clock,
// then the count memory is read for the slot it settled on, then update and result.
// Reset clears the cells, entry valid bits and total.
// The result register lets the next item be accepted while a result waits;
// an item whose result is ready holds in its last step until it drains.
// ----------------------------------------------------------------------------
module per_slot_counter_merge_table_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: thread_key[63:0], slot[70:64], amount[102:71], zero pad
    input  logic [pscm_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: command[1:0]
    input  logic [pscm_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: slot_out[6:0], weak_value[38:7], global_total[70:39], zero pad
    output logic [pscm_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: status[0]
    output logic [pscm_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import pscm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_FETCH  = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    // Input field split
    logic [KEY_W-1:0]  in_key;
    logic [SLOT_W-1:0] in_slot;
    logic [VAL_W-1:0]  in_amount;
    pscm_cmd_t         in_cmd;

    assign in_key    = s_tdata[S_KEY_LSB +: KEY_W];
    assign in_slot   = s_tdata[S_SLOT_LSB +: SLOT_W];
    assign in_amount = s_tdata[S_AMT_LSB +: VAL_W];
    assign in_cmd    = pscm_cmd_t'(s_tuser[CMD_W-1:0]);

    state_t            state_reg, state_next;
    pscm_cmd_t         cmd_reg, cmd_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SLOT_W-1:0] slot7_reg, slot7_next;
    logic              inrange_reg, inrange_next;
    logic              status_reg, status_next;
    logic [VAL_W-1:0]  amount_reg, amount_next;
    logic [VAL_W-1:0]  merged_reg, merged_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // Count memory: {seen_total, pending_count} per slot, valid bits for reset
    logic [2*VAL_W-1:0] cnt_mem [SLOTS];
    logic               ent_valid_reg [SLOTS];
    logic [2*VAL_W-1:0] rd_data_reg;
    logic               rd_valid_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [2*VAL_W-1:0] wr_data;

    pscm_tok_t tok_in;
    pscm_tok_t tok_out;

    logic             accept;
    logic             fire;
    logic [VAL_W-1:0] pend, seen, new_pend, new_seen, weak_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Key search row
    always_comb begin
        tok_in.valid = accept && (in_cmd == CMD_LOOKUP);
        tok_in.hit   = 1'b0;
        tok_in.idx   = '0;
        tok_in.key   = in_key[KEY_WIDTH-1:0];
    end

    pscm_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tok_in  (tok_in),
        .tok_out (tok_out)
    );

    // Sequencer and item registers
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        slot7_next   = slot7_reg;
        inrange_next = inrange_reg;
        status_next  = status_reg;
        amount_next  = amount_reg;
        rd_en        = 1'b0;
        rd_addr      = IDX_W'(in_slot);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next     = in_cmd;
                    idx_next     = IDX_W'(in_slot);
                    slot7_next   = in_slot;
                    inrange_next = (32'(in_slot) < SLOTS);
                    status_next  = 1'b0;
                    amount_next  = in_amount;
                    if (in_cmd == CMD_LOOKUP) begin
                        state_next = ST_SEARCH;
                    end else begin
                        rd_en      = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SEARCH: begin
                if (tok_out.valid) begin
                    state_next = ST_FETCH;
                    if (tok_out.hit) begin
                        idx_next     = tok_out.idx;
                        slot7_next   = SLOT_W'(tok_out.idx);
                        inrange_next = 1'b1;
                        status_next  = 1'b0;
                    end else begin
                        idx_next     = '0;
                        slot7_next   = '0;
                        inrange_next = 1'b0;
                        status_next  = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                // Read the counts of the slot the search settled on
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Counter update on the fetched entry
    always_comb begin
        pend        = rd_valid_reg ? rd_data_reg[VAL_W-1:0] : '0;
        seen        = rd_valid_reg ? rd_data_reg[2*VAL_W-1:VAL_W] : '0;
        new_pend    = pend;
        new_seen    = seen;
        merged_next = merged_reg;
        wr_en       = 1'b0;
        case (cmd_reg)
            CMD_ADD: begin
                new_pend = pend + amount_reg;
                wr_en    = fire && inrange_reg;
            end
            CMD_MERGE: begin
                if (inrange_reg) begin
                    merged_next = merged_reg + pend;
                end
                new_seen = merged_next;
                new_pend = '0;
                wr_en    = fire && inrange_reg;
            end
            default: begin
                new_pend = pend;
            end
        endcase
        if (!fire) begin
            merged_next = merged_reg;
        end
        weak_sum = inrange_reg ? (new_seen + new_pend) : '0;
        wr_data  = {new_seen, new_pend};
    end

    // Result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[M_SLOT_LSB +: SLOT_W] = slot7_reg;
            m_tdata_next[M_WEAK_LSB +: VAL_W]  = weak_sum;
            m_tdata_next[M_GLOB_LSB +: VAL_W]  = merged_next;
            m_tuser_next  = M_TUSER_W'(status_reg);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            merged_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            merged_reg   <= merged_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        slot7_reg   <= slot7_next;
        inrange_reg <= inrange_next;
        status_reg  <= status_next;
        amount_reg  <= amount_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Entry valid bits: a slot never written reads as zero counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                ent_valid_reg[i] <= 1'b0;
            end
        end else if (wr_en) begin
            ent_valid_reg[idx_reg] <= 1'b1;
        end
    end

    // Count memory write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cnt_mem[idx_reg] <= wr_data;
        end
    end

    // Count memory read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= cnt_mem[rd_addr];
            rd_valid_reg <= ent_valid_reg[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> dv/per_slot_counter_merge_table_top_tb.sv
// ----------------------------------------------------------------------------
// per_slot_counter_merge_table_top_tb - self-checking bench for the counter table
// Drives lookups, adds, merges and plain reads on the input stream. A local
// model of the key table, pending counts, seen totals and the merged total
// predicts each result. Results are compared field by field, in order.
// ----------------------------------------------------------------------------
module per_slot_counter_merge_table_top_tb;
    import pscm_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int DRAIN_CYCLES = SLOTS + 8;

    // One predicted result transaction
    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic [VAL_W-1:0]  weak_value;
        logic [VAL_W-1:0]  global_total;
        logic [STAT_W-1:0] status;
    } counter_result_t;

    // DUT connections, all inputs known from time zero
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // Local copy of the block state
    logic [KEY_WIDTH-1:0] key_cells    [SLOTS];
    logic [VAL_W-1:0]     pending_cnt  [SLOTS];
    logic [VAL_W-1:0]     seen_total   [SLOTS];
    logic [VAL_W-1:0]     merged_total = '0;
    int                   slots_taken  = 0;

    counter_result_t expected_tallies[$];

    int  items_sent      = 0;
    int  results_seen    = 0;
    int  mismatches      = 0;
    int  cycle_count     = 0;
    int  hold_off_cycles = 0;
    bit  steady          = 1'b0;

    per_slot_counter_merge_table_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Clock, period 20
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Predict one transaction and advance the local state
    function automatic counter_result_t predict_counter_update(
        input pscm_cmd_t         cmd,
        input logic [KEY_W-1:0]  key,
        input logic [SLOT_W-1:0] slot,
        input logic [VAL_W-1:0]  amt
    );
        counter_result_t      r;
        logic [KEY_WIDTH-1:0] k;
        int                   idx;
        int                   hit;
        int                   i;
        k        = key[KEY_WIDTH-1:0];
        idx      = int'(slot);
        r.status = '0;
        case (cmd)
            CMD_LOOKUP: begin
                hit = -1;
                for (i = 0; i < slots_taken; i++)
                    if (hit < 0 && key_cells[i] == k)
                        hit = i;
                if (hit >= 0) begin
                    idx = hit;
                end else if (slots_taken < SLOTS) begin
                    idx = slots_taken;
                    key_cells[idx] = k;
                    slots_taken++;
                end else begin
                    // table full: nothing assigned
                    idx      = -1;
                    r.status = 1'b1;
                end
            end
            CMD_ADD: begin
                if (idx < SLOTS)
                    pending_cnt[idx] = pending_cnt[idx] + amt;
            end
            CMD_MERGE: begin
                if (idx < SLOTS) begin
                    merged_total     = merged_total + pending_cnt[idx];
                    seen_total[idx]  = merged_total;
                    pending_cnt[idx] = '0;
                end
            end
            default: ;
        endcase
        r.slot_out     = (idx < 0) ? '0 : idx[SLOT_W-1:0];
        r.weak_value   = (idx >= 0 && idx < SLOTS) ? seen_total[idx] + pending_cnt[idx] : '0;
        r.global_total = merged_total;
        return r;
    endfunction

    // Amounts: mostly random, sometimes at the extremes
    function automatic logic [VAL_W-1:0] draw_amount();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Random slot number within the table
    function automatic logic [SLOT_W-1:0] draw_slot();
        return SLOT_W'($urandom_range(0, SLOTS - 1));
    endfunction

    // Offer one transaction, wait for acceptance, record its prediction
    task automatic send_command(
        input  pscm_cmd_t         cmd,
        input  logic [KEY_W-1:0]  key,
        input  logic [SLOT_W-1:0] slot,
        input  logic [VAL_W-1:0]  amt,
        output counter_result_t   res
    );
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap  = steady ? 0 : $urandom_range(0, 16);
        word = '0;
        word[S_KEY_LSB  +: KEY_W]  = key;
        word[S_SLOT_LSB +: SLOT_W] = slot;
        word[S_AMT_LSB  +: VAL_W]  = amt;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= word;
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        res = predict_counter_update(cmd, key, slot, amt);
        expected_tallies = {expected_tallies, res};
        items_sent++;
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s of result %0d: expected %h, got %h",
                     field, results_seen, want, got);
    endtask

    // Result sink: random stalls, long hold-off on request
    initial begin : result_sink
        int stall;
        forever begin
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 16);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Checker: each result transaction against the oldest prediction
    always @(posedge aclk) begin
        counter_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_tallies.size() == 0) begin
                note_mismatch("unexpected result", '0, m_tdata[63:0]);
            end else begin
                want = expected_tallies.pop_front();
                if (m_tdata[M_SLOT_LSB +: SLOT_W] !== want.slot_out)
                    note_mismatch("slot_out", 64'(want.slot_out),
                                  64'(m_tdata[M_SLOT_LSB +: SLOT_W]));
                if (m_tdata[M_WEAK_LSB +: VAL_W] !== want.weak_value)
                    note_mismatch("weak_value", 64'(want.weak_value),
                                  64'(m_tdata[M_WEAK_LSB +: VAL_W]));
                if (m_tdata[M_GLOB_LSB +: VAL_W] !== want.global_total)
                    note_mismatch("global_total", 64'(want.global_total),
                                  64'(m_tdata[M_GLOB_LSB +: VAL_W]));
                if (m_tuser !== want.status)
                    note_mismatch("status", 64'(want.status), 64'(m_tuser));
            end
        end
    end

    // Extremes of every field, each command, unassigned slots and wrapping
    task automatic test_directed_basics();
        counter_result_t res;
        steady = 1'b1;
        send_command(CMD_LOOKUP, 64'h0, 7'd0, 32'h0, res);
        send_command(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 32'hFFFF_FFFF, res);
        send_command(CMD_LOOKUP, 64'h0, 7'd127, 32'h0, res);
        send_command(CMD_ADD, 64'h0, 7'd0, 32'h7FFF_FFFF, res);
        send_command(CMD_ADD, 64'h0, 7'd0, 32'h0000_0001, res);
        send_command(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 32'h8000_0000, res);
        send_command(CMD_ADD, 64'h0, 7'd127, 32'hFFFF_FFFF, res);
        steady = 1'b0;
        // merge on a slot no key holds yet
        send_command(CMD_MERGE, 64'h0, 7'd127, 32'h0, res);
        send_command(CMD_MERGE, 64'h0, 7'd0, 32'h0, res);
        send_command(CMD_READ, 64'h0, 7'd0, 32'h0, res);
        send_command(CMD_READ, 64'h0, 7'd127, 32'hFFFF_FFFF, res);
        send_command(CMD_ADD, 64'h0, 7'd5, 32'd123, res);
        send_command(CMD_LOOKUP, 64'h8000_0000_0000_0000, 7'd0, 32'h0, res);
        send_command(CMD_MERGE, 64'h0, 7'd5, 32'h0, res);
        send_command(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 32'h0, res);
        send_command(CMD_READ, 64'h0, 7'd5, 32'h0, res);
    endtask

    // Mostly lookup / adds / merge sequences on one slot, the rest noise
    task automatic test_random_traffic(input int n_items, input int new_key_pct);
        counter_result_t   res;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
        pscm_cmd_t         cmd;
        int                stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 11) == 0)
                steady = !steady;
            if ($urandom_range(0, 9) < 7) begin
                if (slots_taken > 0 && $urandom_range(0, 99) >= new_key_pct)
                    key = key_cells[$urandom_range(0, slots_taken - 1)];
                else
                    key = {$urandom, $urandom};
                send_command(CMD_LOOKUP, key, draw_slot(), $urandom, res);
                slot = res.status ? draw_slot() : res.slot_out;
                repeat ($urandom_range(1, 4))
                    send_command(CMD_ADD, {$urandom, $urandom}, slot, draw_amount(), res);
                if ($urandom_range(0, 3) == 0)
                    send_command(CMD_READ, {$urandom, $urandom}, slot, draw_amount(), res);
                send_command(CMD_MERGE, {$urandom, $urandom}, slot, draw_amount(), res);
            end else begin
                cmd = pscm_cmd_t'($urandom_range(0, 3));
                send_command(cmd, {$urandom, $urandom}, draw_slot(), draw_amount(), res);
            end
        end
        steady = 1'b0;
    endtask

    // Assign fresh keys until every slot is taken
    task automatic test_fill_table();
        counter_result_t res;
        while (slots_taken < SLOTS) begin
            send_command(CMD_LOOKUP, {$urandom, $urandom}, draw_slot(), $urandom, res);
            if ($urandom_range(0, 3) == 0)
                send_command(CMD_ADD, {$urandom, $urandom}, res.slot_out, draw_amount(), res);
        end
    endtask

    // New key on a full table, then hits on the first and last slots
    task automatic test_table_full();
        counter_result_t res;
        send_command(CMD_LOOKUP, {$urandom, $urandom}, 7'd99, 32'h0, res);
        send_command(CMD_LOOKUP, 64'h0000_0000_0000_0001, 7'd0, 32'h0, res);
        send_command(CMD_LOOKUP, key_cells[0], 7'd3, 32'h0, res);
        send_command(CMD_LOOKUP, key_cells[SLOTS - 1], 7'd0, 32'h0, res);
        send_command(CMD_ADD, 64'h0, 7'd127, 32'h8000_0000, res);
        send_command(CMD_MERGE, 64'h0, 7'd127, 32'h0, res);
    endtask

    // Long receiver hold-off while the sender keeps offering back to back
    task automatic test_backpressure();
        counter_result_t res;
        hold_off_cycles = 300;
        steady          = 1'b1;
        repeat (24)
            send_command(pscm_cmd_t'($urandom_range(1, 3)), {$urandom, $urandom},
                         draw_slot(), draw_amount(), res);
        steady = 1'b0;
    endtask

    // Sequence of tests
    initial begin
        int i;
        for (i = 0; i < SLOTS; i++) begin
            pending_cnt[i] = '0;
            seen_total[i]  = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_basics();
        test_random_traffic(340, 40);
        test_fill_table();
        test_table_full();
        test_backpressure();
        test_random_traffic(340, 10);

        s_tvalid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_tallies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
